// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

	// default capacity of the heap
	localparam int unsigned MAX_ENTRIES_DEF = 256;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned COUNT_W  = 9;
	localparam int unsigned STATUS_W = 2;

	// item kinds
	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                kind;
		logic [KEY_W-1:0]    entry_key;
		logic [HANDLE_W-1:0] entry_handle;
	} req_t;

	typedef struct packed {
		logic                result_valid;
		logic [KEY_W-1:0]    result_key;
		logic [HANDLE_W-1:0] result_handle;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

	// one heap slot
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

// ===== design/mhpq_store.sv =====
module mhpq_store #(
	parameter int unsigned DEPTH = mhpq_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  mhpq_pkg::entry_t        wr_data,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output mhpq_pkg::entry_t        rd_data
);

	// heap slots, contents undefined until written
	mhpq_pkg::entry_t mem_q [DEPTH];
	mhpq_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/mhpq_seq.sv =====
module mhpq_seq #(
	parameter int unsigned MAX_ENTRIES = mhpq_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned AW          = $clog2(MAX_ENTRIES),
	parameter int unsigned CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// item start
	input  logic               start,
	input  mhpq_pkg::req_t     req,
	output logic               idle,
	// finished result
	output logic               res_valid,
	input  logic               res_ready,
	output mhpq_pkg::rsp_t     res,
	// slot store
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output mhpq_pkg::entry_t   wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  mhpq_pkg::entry_t   rd_data
);

	// child index width: 2*pos+2 fits
	localparam int unsigned IW = AW + 2;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_CMP  = 4'd1;
	localparam logic [3:0] S_UP_PUT  = 4'd2;
	localparam logic [3:0] S_DN_ROOT = 4'd3;
	localparam logic [3:0] S_DN_LAST = 4'd4;
	localparam logic [3:0] S_DN_L    = 4'd5;
	localparam logic [3:0] S_DN_R    = 4'd6;
	localparam logic [3:0] S_DN_PUT  = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]                      state_q, state_d;
	logic [CW-1:0]                   count_q, count_d;
	logic [AW-1:0]                   pos_q, pos_d;
	mhpq_pkg::entry_t                mov_q, mov_d;
	mhpq_pkg::entry_t                best_q, best_d;
	logic                            bchild_q, bchild_d;
	logic                            rvalid_q, rvalid_d;
	mhpq_pkg::entry_t                rent_q, rent_d;
	logic [mhpq_pkg::STATUS_W-1:0]   status_q, status_d;

	// the one shared key comparator
	logic [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
	logic                       lt;

	logic [IW-1:0] lc, rc, cnt_ext, idx_c, nlc;
	logic [AW-1:0] parent;
	logic [AW-1:0] npos;
	mhpq_pkg::entry_t best_c;
	logic          child_c;
	logic          do_move;

	always_comb begin
		cmp_a = rd_data.key;
		cmp_b = best_q.key;
		if (state_q == S_UP_CMP) begin
			cmp_a = mov_q.key;
			cmp_b = rd_data.key;
		end else if (state_q == S_DN_L) begin
			cmp_b = mov_q.key;
		end
	end

	assign lt      = cmp_a < cmp_b;
	assign lc      = {1'b0, pos_q, 1'b1};
	assign rc      = lc + IW'(1);
	assign cnt_ext = IW'(count_q);
	assign parent  = (pos_q - AW'(1)) >> 1;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pos_d    = pos_q;
		mov_d    = mov_q;
		best_d   = best_q;
		bchild_d = bchild_q;
		rvalid_d = rvalid_q;
		rent_d   = rent_q;
		status_d = status_q;
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_data  = mov_q;
		rd_en    = 1'b0;
		rd_addr  = parent;
		best_c   = best_q;
		child_c  = 1'b0;
		idx_c    = lc;
		do_move  = 1'b0;
		npos     = idx_c[AW-1:0];
		nlc      = lc;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mov_d    = '{key: req.entry_key, handle: req.entry_handle};
					rvalid_d = 1'b0;
					rent_d   = '0;
					status_d = mhpq_pkg::ST_OK;
					if (req.kind == mhpq_pkg::KIND_INSERT) begin
						if (count_q >= CW'(MAX_ENTRIES)) begin
							status_d = mhpq_pkg::ST_FULL;
							state_d  = S_DONE;
						end else begin
							pos_d   = count_q[AW-1:0];
							count_d = count_q + CW'(1);
							if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = '{key: req.entry_key, handle: req.entry_handle};
								state_d = S_DONE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = (count_q[AW-1:0] - AW'(1)) >> 1;
								state_d = S_UP_CMP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = mhpq_pkg::ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							count_d = count_q - CW'(1);
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = S_DN_ROOT;
						end
					end
				end
			end
			S_UP_CMP: begin
				if (lt) begin
					// parent moves down into the hole
					wr_en   = 1'b1;
					wr_data = rd_data;
					pos_d   = parent;
					if (parent == '0) begin
						state_d = S_UP_PUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = (parent - AW'(1)) >> 1;
					end
				end else begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_UP_PUT: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_DN_ROOT: begin
				rvalid_d = 1'b1;
				rent_d   = rd_data;
				if (count_q == '0) begin
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = count_q[AW-1:0];
					state_d = S_DN_LAST;
				end
			end
			S_DN_LAST: begin
				mov_d = rd_data;
				pos_d = '0;
				if (count_q > CW'(1)) begin
					rd_en   = 1'b1;
					rd_addr = AW'(1);
					state_d = S_DN_L;
				end else begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = rd_data;
					state_d = S_DONE;
				end
			end
			S_DN_L: begin
				best_c  = lt ? rd_data : mov_q;
				child_c = lt;
				idx_c   = lc;
				if (rc < cnt_ext) begin
					best_d   = best_c;
					bchild_d = lt;
					rd_en    = 1'b1;
					rd_addr  = rc[AW-1:0];
					state_d  = S_DN_R;
				end else begin
					do_move = 1'b1;
				end
			end
			S_DN_R: begin
				best_c  = lt ? rd_data : best_q;
				child_c = lt | bchild_q;
				idx_c   = lt ? rc : lc;
				do_move = 1'b1;
			end
			S_DN_PUT: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// one level of sift-down settled
		if (do_move) begin
			npos = idx_c[AW-1:0];
			nlc  = {1'b0, npos, 1'b1};
			wr_en = 1'b1;
			if (child_c) begin
				wr_data = best_c;
				pos_d   = npos;
				if (nlc < cnt_ext) begin
					rd_en   = 1'b1;
					rd_addr = nlc[AW-1:0];
					state_d = S_DN_L;
				end else begin
					state_d = S_DN_PUT;
				end
			end else begin
				state_d = S_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		mov_q    <= mov_d;
		best_q   <= best_d;
		bchild_q <= bchild_d;
		rvalid_q <= rvalid_d;
		rent_q   <= rent_d;
		status_q <= status_d;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.result_valid  = rvalid_q;
		res.result_key    = rent_q.key;
		res.result_handle = rent_q.handle;
		res.status        = status_q;
		res.entry_count   = mhpq_pkg::COUNT_W'(count_q);
	end

	// held count never passes capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("held count above capacity");

	// a returned entry always comes with ok status
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_valid) |-> (res.status == mhpq_pkg::ST_OK))
		else $error("returned entry with bad status");

	// store is left alone between items
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(idle || res_valid) |-> !(rd_en && !start) && !(wr_en && !start))
		else $error("store access outside an item");

	// insert with room grows the heap by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && idle && req.kind == mhpq_pkg::KIND_INSERT && count_q < CW'(MAX_ENTRIES))
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow count");

endmodule

// ===== design/min_heap_priority_queue_unit.sv =====
// channel   dir  handshake              payload
// req       in   req_valid / req_ready  mhpq_pkg::req_t (kind, entry_key, entry_handle)
// rsp       out  rsp_valid / rsp_ready  mhpq_pkg::rsp_t (result fields, status, entry_count)
//
// one item at a time; the one key comparator and the single-read slot store set the pace
// insert: the new entry climbs one level per comparison, at most 8 levels at 256; an empty heap takes it at the root
// extract: the root is returned and the last entry sinks from the root, each level comparing the
//   left child and then the right one if present; no sinking when it leaves 0 or 1 entries
// insert on full or extract on empty goes straight to the result; reset clears the state, held count and output valid
// a waiting result sits in the output register, so a stalled rsp holds the next item only
module min_heap_priority_queue_unit #(
	parameter int unsigned MAX_ENTRIES = mhpq_pkg::MAX_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mhpq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mhpq_pkg::rsp_t  rsp
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	logic             seq_idle;
	logic             start;
	logic             res_valid;
	logic             res_ready;
	mhpq_pkg::rsp_t   res;

	// store port wires
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	mhpq_pkg::entry_t wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	mhpq_pkg::entry_t rd_data;

	// output register
	logic             rsp_valid_q;
	mhpq_pkg::rsp_t   rsp_q;

	// a new item is taken whenever the sequencer is free
	assign req_ready = seq_idle;
	assign start     = req_valid && req_ready;

	// the sequencer may hand over when the output register is empty or draining
	assign res_ready = !rsp_valid_q || rsp_ready;

	mhpq_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	mhpq_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result transfer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a held result is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> $stable(rsp_q))
		else $error("stalled result overwritten");

	// items are taken only while no item is in work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req_ready)
		else $error("second item taken during work");

	// each handed-over result reaches the output register
	a_handover: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> rsp_valid_q)
		else $error("result lost at handover");

endmodule
